FILE: hdl/sff_pkg.sv
// ----------------------------------------------------------------------------
// sff_pkg
// Types, codes and constants shared by the serial frame finalizer files.
// ----------------------------------------------------------------------------
package sff_pkg;

  localparam int SFF_FRAME_BYTES = 64;

  // configuration register file
  localparam int NUM_CFG   = 5;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEND_DATA        = 3'd0,
    CFG_ENCAP_CLASS      = 3'd1,
    CFG_CHANNEL_ENCAP    = 3'd2,
    CFG_INSTANCE_ENCAP   = 3'd3,
    CFG_CALLBACK_RESTART = 3'd4
  } cfg_idx_e;

  localparam logic [7:0] SEND_DATA_RST        = 8'd19;
  localparam logic [7:0] ENCAP_CLASS_RST      = 8'd96;
  localparam logic [7:0] CHANNEL_ENCAP_RST    = 8'd13;
  localparam logic [7:0] INSTANCE_ENCAP_RST   = 8'd6;
  localparam logic [7:0] CALLBACK_RESTART_RST = 8'd10;
  localparam logic [7:0] CALLBACK_CNT_RST     = 8'd10;

  localparam logic [7:0] CHECKSUM_SEED   = 8'hFF;
  localparam logic [7:0] MC_CHANNEL_MARK = 8'd1;

  // frame layout
  localparam int LENGTH_IDX      = 1;
  localparam int FUNC_IDX        = 3;
  localparam int PAYLOAD_LEN_IDX = 5;
  localparam int ENCAP_AT        = 6;
  localparam int MIN_ENCAP_LEN   = 6;
  localparam int MC_HDR_BYTES    = 4;
  localparam int MI_HDR_BYTES    = 3;

  typedef enum logic [1:0] {
    MODE_LOAD     = 2'd0,
    MODE_FINALIZE = 2'd1,
    MODE_REISSUE  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_NO_FRAME = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_SHIFT,
    S_B5RD,
    S_B5WR,
    S_HDR,
    S_CB,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       callback_wanted;
    logic       multichannel;
    logic       multiinstance;
    logic [7:0] endpoint;
    logic [7:0] instance_number;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
    logic [1:0] status;
  } out_beat_t;

endpackage

FILE: hdl/sff_stream_if.sv
// ----------------------------------------------------------------------------
// sff_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface sff_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

FILE: hdl/sff_ram.sv
// ----------------------------------------------------------------------------
// sff_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/serial_frame_finalizer_unit.sv
// ----------------------------------------------------------------------------
// serial_frame_finalizer_unit
// Collects message bytes, finalizes them into a serial frame and streams it.
// ----------------------------------------------------------------------------
// A load beat is written to the frame RAM and the next beat is accepted right
// after it unless the output buffer is full. A finalize runs as a sequence
// over the single frame RAM: it reads the function byte, then, when an
// encapsulation header goes in, moves each payload byte up (frame length minus
// 6 bytes), reads and patches the payload length and writes the three or four
// header bytes, then writes a callback id if one is wanted, and then the frame
// streams out at one beat per cycle from the registered RAM read port, with
// the checksum computed on the fly and written back as the last beat. Output
// stalls hold the stream back beat for beat. A reissue starts its stream in
// the next cycle. Error results are a single beat. No new input is taken
// until a finalize or reissue has handed all its beats to the two-entry output
// buffer. The frame RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
module serial_frame_finalizer_unit
  import sff_pkg::*;
#(
  parameter int FRAME_BYTES = SFF_FRAME_BYTES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  sff_stream_if.sink           in_i,
  sff_stream_if.source         out_o
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int LW = $clog2(FRAME_BYTES + 1);
  localparam int TW = $clog2(FRAME_BYTES + 7);

  in_beat_t in_beat;
  assign in_beat = in_i.payload;

  state_e state_q, state_d;

  logic [7:0]    cfg_q [NUM_CFG];
  logic [LW-1:0] flen_q, flen_d;
  logic          done_q, done_d;
  logic          ovf_q, ovf_d;
  logic          hascb_q, hascb_d;
  logic [7:0]    cnt_q, cnt_d;

  // latched finalize request
  logic       req_cb_q, req_cb_d;
  logic       req_mc_q, req_mc_d;
  logic       req_mi_q, req_mi_d;
  logic [7:0] ep_q, ep_d;
  logic [7:0] inst_q, inst_d;

  logic [2:0]    ext_q, ext_d;
  logic [AW-1:0] sh_q, sh_d;
  logic [AW-1:0] lext_q, lext_d;
  logic [1:0]    hd_q, hd_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pend_addr_q, pend_addr_d;

  // stream sequencer
  logic [LW-1:0] em_rd_q, em_rd_d;
  logic          em_pend_q, em_pend_d;
  logic          em_sum_q, em_sum_d;
  logic [AW-1:0] em_idx_q, em_idx_d;
  logic [7:0]    sum_q, sum_d;

  // output buffer
  out_beat_t fifo_q [2];
  logic      fifo_wp_q, fifo_rp_q;
  logic [1:0] occ_q;
  logic      push;
  out_beat_t push_beat;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic          accept, pop;
  logic [7:0]    cb_id;
  logic          enc_hit;
  logic [2:0]    chk_ext;
  logic [TW-1:0] chk_total;
  logic          chk_fit;
  logic [LW-1:0] chk_lext, flen_m1, flen_m2;
  logic          em_issue;
  logic [7:0]    hdr_byte;

  assign in_i.ready  = (state_q == S_IDLE) && (occ_q != 2'd2);
  assign accept      = in_i.valid && in_i.ready;
  assign out_o.valid = (occ_q != 2'd0);
  assign out_o.payload = fifo_q[fifo_rp_q];
  assign pop         = out_o.valid && out_o.ready;

  assign cb_id = (cnt_q == 8'd0) ? cfg_q[CFG_CALLBACK_RESTART] : cnt_q;

  assign enc_hit   = (req_mc_q || req_mi_q) && (flen_q >= LW'(MIN_ENCAP_LEN))
                     && (ram_rdata == cfg_q[CFG_SEND_DATA]);
  assign chk_ext   = enc_hit ? (req_mc_q ? 3'(MC_HDR_BYTES) : 3'(MI_HDR_BYTES)) : 3'd0;
  assign chk_total = TW'(flen_q) + TW'(chk_ext) + TW'(req_cb_q) + TW'(1);
  assign chk_fit   = (chk_total <= TW'(FRAME_BYTES));
  assign chk_lext  = flen_q + LW'(chk_ext);
  assign flen_m1   = flen_q - LW'(1);
  assign flen_m2   = flen_q - LW'(2);

  assign em_issue = (state_q == S_EMIT) && (em_rd_q < flen_q)
                    && ((3'(occ_q) + 3'(em_pend_q)) < (3'd2 + 3'(pop)));

  always_comb begin
    case (hd_q)
      2'd0:    hdr_byte = cfg_q[CFG_ENCAP_CLASS];
      2'd1:    hdr_byte = req_mc_q ? cfg_q[CFG_CHANNEL_ENCAP] : cfg_q[CFG_INSTANCE_ENCAP];
      2'd2:    hdr_byte = req_mc_q ? MC_CHANNEL_MARK : inst_q;
      default: hdr_byte = ep_q;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_beat.mode)
            MODE_FINALIZE: begin
              if (done_q) begin
                state_d = S_EMIT;
              end else if (!ovf_q && (flen_q != '0)) begin
                state_d = S_CHK;
              end
            end
            MODE_REISSUE: begin
              if (done_q) begin
                state_d = S_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_CHK: begin
        if (!chk_fit) begin
          state_d = S_IDLE;
        end else if (chk_ext != 3'd0) begin
          state_d = (flen_q > LW'(ENCAP_AT)) ? S_SHIFT : S_B5RD;
        end else if (req_cb_q) begin
          state_d = S_CB;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_SHIFT: begin
        if (sh_q == AW'(ENCAP_AT)) begin
          state_d = S_B5RD;
        end
      end
      S_B5RD: state_d = S_B5WR;
      S_B5WR: state_d = S_HDR;
      S_HDR: begin
        if (hd_q == 2'(ext_q - 3'd1)) begin
          state_d = req_cb_q ? S_CB : S_EMIT;
        end
      end
      S_CB: state_d = S_EMIT;
      S_EMIT: begin
        if (em_pend_q && em_sum_q) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    flen_d      = flen_q;
    done_d      = done_q;
    ovf_d       = ovf_q;
    hascb_d     = hascb_q;
    cnt_d       = cnt_q;
    req_cb_d    = req_cb_q;
    req_mc_d    = req_mc_q;
    req_mi_d    = req_mi_q;
    ep_d        = ep_q;
    inst_d      = inst_q;
    ext_d       = ext_q;
    sh_d        = sh_q;
    lext_d      = lext_q;
    hd_d        = hd_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    em_rd_d     = em_rd_q;
    em_pend_d   = 1'b0;
    em_sum_d    = em_sum_q;
    em_idx_d    = em_idx_q;
    sum_d       = sum_q;
    push        = 1'b0;
    push_beat   = '{frame_byte: 8'd0, last_byte: 1'b1, status: STATUS_OK};
    ram_raddr   = '0;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;

    // moved payload byte is written in the cycle after its read
    if (pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_q;
      ram_wdata = ram_rdata;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_beat.mode)
            MODE_LOAD: begin
              if (done_q) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = in_beat.data_byte;
                flen_d    = LW'(1);
                done_d    = 1'b0;
                ovf_d     = 1'b0;
                hascb_d   = 1'b0;
              end else if (flen_q < LW'(FRAME_BYTES)) begin
                ram_we    = 1'b1;
                ram_waddr = flen_q[AW-1:0];
                ram_wdata = in_beat.data_byte;
                flen_d    = flen_q + LW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            MODE_FINALIZE: begin
              if (done_q) begin
                // restream the finished frame
              end else if (ovf_q) begin
                flen_d    = '0;
                ovf_d     = 1'b0;
                push      = 1'b1;
                push_beat.status = STATUS_OVERFLOW;
              end else if (flen_q == '0) begin
                push      = 1'b1;
                push_beat.status = STATUS_NO_FRAME;
              end else begin
                req_cb_d  = in_beat.callback_wanted;
                req_mc_d  = in_beat.multichannel;
                req_mi_d  = in_beat.multiinstance;
                ep_d      = in_beat.endpoint;
                inst_d    = in_beat.instance_number;
                ram_raddr = AW'(FUNC_IDX);
              end
            end
            MODE_REISSUE: begin
              if (!done_q) begin
                push      = 1'b1;
                push_beat.status = STATUS_NO_FRAME;
              end else if (hascb_q && (flen_q >= LW'(2))) begin
                ram_we    = 1'b1;
                ram_waddr = flen_m2[AW-1:0];
                ram_wdata = cb_id;
                cnt_d     = cb_id + 8'd1;
              end
            end
            default: ;
          endcase
        end
      end
      S_CHK: begin
        if (!chk_fit) begin
          flen_d    = '0;
          push      = 1'b1;
          push_beat.status = STATUS_OVERFLOW;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = AW'(LENGTH_IDX);
          ram_wdata = 8'(chk_total - TW'(2));
          done_d    = 1'b1;
          flen_d    = chk_total[LW-1:0];
          hascb_d   = req_cb_q;
          ext_d     = chk_ext;
          lext_d    = chk_lext[AW-1:0];
          sh_d      = flen_m1[AW-1:0];
          hd_d      = 2'd0;
        end
      end
      S_SHIFT: begin
        ram_raddr   = sh_q;
        pend_d      = 1'b1;
        pend_addr_d = sh_q + AW'(ext_q);
        sh_d        = sh_q - AW'(1);
      end
      S_B5RD: begin
        ram_raddr = AW'(PAYLOAD_LEN_IDX);
      end
      S_B5WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(PAYLOAD_LEN_IDX);
        ram_wdata = ram_rdata + 8'(ext_q);
      end
      S_HDR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(ENCAP_AT) + AW'(hd_q);
        ram_wdata = hdr_byte;
        hd_d      = hd_q + 2'd1;
      end
      S_CB: begin
        ram_we    = 1'b1;
        ram_waddr = lext_q;
        ram_wdata = cb_id;
        cnt_d     = cb_id + 8'd1;
      end
      S_EMIT: begin
        if (em_issue) begin
          ram_raddr = em_rd_q[AW-1:0];
          em_pend_d = 1'b1;
          em_idx_d  = em_rd_q[AW-1:0];
          em_sum_d  = (em_rd_q == flen_m1);
          em_rd_d   = em_rd_q + LW'(1);
        end
        if (em_pend_q) begin
          push = 1'b1;
          if (em_sum_q) begin
            // checksum slot: no read, value goes out and back into the frame
            push_beat = '{frame_byte: sum_q, last_byte: 1'b1, status: STATUS_OK};
            ram_we    = 1'b1;
            ram_waddr = em_idx_q;
            ram_wdata = sum_q;
          end else begin
            push_beat = '{frame_byte: ram_rdata, last_byte: 1'b0, status: STATUS_OK};
            if (em_idx_q != '0) begin
              sum_d = sum_q ^ ram_rdata;
            end
          end
        end
      end
      default: ;
    endcase

    if ((state_d == S_EMIT) && (state_q != S_EMIT)) begin
      em_rd_d   = '0;
      em_pend_d = 1'b0;
      sum_d     = CHECKSUM_SEED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[CFG_SEND_DATA]        <= SEND_DATA_RST;
      cfg_q[CFG_ENCAP_CLASS]      <= ENCAP_CLASS_RST;
      cfg_q[CFG_CHANNEL_ENCAP]    <= CHANNEL_ENCAP_RST;
      cfg_q[CFG_INSTANCE_ENCAP]   <= INSTANCE_ENCAP_RST;
      cfg_q[CFG_CALLBACK_RESTART] <= CALLBACK_RESTART_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_SEND_DATA)        cfg_q[CFG_SEND_DATA]        <= cfg_data_i;
      if (cfg_idx_i == CFG_ENCAP_CLASS)      cfg_q[CFG_ENCAP_CLASS]      <= cfg_data_i;
      if (cfg_idx_i == CFG_CHANNEL_ENCAP)    cfg_q[CFG_CHANNEL_ENCAP]    <= cfg_data_i;
      if (cfg_idx_i == CFG_INSTANCE_ENCAP)   cfg_q[CFG_INSTANCE_ENCAP]   <= cfg_data_i;
      if (cfg_idx_i == CFG_CALLBACK_RESTART) cfg_q[CFG_CALLBACK_RESTART] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      flen_q    <= '0;
      done_q    <= 1'b0;
      ovf_q     <= 1'b0;
      hascb_q   <= 1'b0;
      cnt_q     <= CALLBACK_CNT_RST;
      pend_q    <= 1'b0;
      em_pend_q <= 1'b0;
      em_rd_q   <= '0;
      hd_q      <= 2'd0;
      sh_q      <= '0;
      fifo_wp_q <= 1'b0;
      fifo_rp_q <= 1'b0;
      occ_q     <= 2'd0;
    end else begin
      state_q   <= state_d;
      flen_q    <= flen_d;
      done_q    <= done_d;
      ovf_q     <= ovf_d;
      hascb_q   <= hascb_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      em_pend_q <= em_pend_d;
      em_rd_q   <= em_rd_d;
      hd_q      <= hd_d;
      sh_q      <= sh_d;
      if (push) begin
        fifo_wp_q <= ~fifo_wp_q;
      end
      if (pop) begin
        fifo_rp_q <= ~fifo_rp_q;
      end
      occ_q <= occ_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    req_cb_q    <= req_cb_d;
    req_mc_q    <= req_mc_d;
    req_mi_q    <= req_mi_d;
    ep_q        <= ep_d;
    inst_q      <= inst_d;
    ext_q       <= ext_d;
    lext_q      <= lext_d;
    pend_addr_q <= pend_addr_d;
    em_sum_q    <= em_sum_d;
    em_idx_q    <= em_idx_d;
    sum_q       <= sum_d;
    if (push) begin
      fifo_q[fifo_wp_q] <= push_beat;
    end
  end

  sff_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= 2'd2)
    else $error("output buffer over capacity");

  a_sum_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && em_pend_q && em_sum_q) |=> (state_q == S_IDLE))
    else $error("stream did not end after checksum beat");

  a_emit_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && ram_we) |-> (em_pend_q && em_sum_q))
    else $error("frame written during stream outside checksum slot");

  a_done_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (flen_q >= LW'(2)))
    else $error("finished frame shorter than two bytes");

  a_shift_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (pend_addr_q > sh_q))
    else $error("payload move would overwrite an unread byte");

endmodule
